>>> rtl/bffba_pkg.sv
`default_nettype none
package bffba_pkg;

	localparam int MAP_WORD_BITS = 64;
	localparam int BYTES_W       = 25;
	localparam int START_W       = 12;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [1:0] STATUS_BAD      = 2'd2;

	typedef struct packed {
		logic               op;
		logic [BYTES_W-1:0] request_bytes;
		logic [START_W-1:0] start_block;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] run_start;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/bffba_ram.sv
`default_nettype none
module bffba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/bitmap_first_fit_block_allocator.sv
`default_nettype none
// Channel  Valid      Stall      Payload  Transaction
// request  req_valid  req_stall  req      op, request_bytes, start_block
// result   rsp_valid  rsp_stall  rsp      status, run_start (one per request)
//
// After reset the map RAM is swept to all free, one word a cycle over all MAP_WORDS words
// (64 at the defaults), with req_stall high.
// Each request computes the block count (reciprocal multiply), then runs the checks;
// then an allocate reads each 64-bit map word and scans it 8 blocks per cycle,
// and each map word marked or cleared is read, then written back; then the result posts.
// One request is in work at a time; the next is taken once the result is in the output
// register, which holds it while rsp_stall is high.
module bitmap_first_fit_block_allocator
	import bffba_pkg::*;
#(
	parameter int TOTAL_BLOCKS    = 4096,
	parameter int BYTES_PER_BLOCK = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int MAP_WORDS = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	// block index over the whole RAM, able to hold its end
	localparam int IW = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
	// block count, able to hold TOTAL_BLOCKS
	localparam int BW = $clog2(TOTAL_BLOCKS + 1);
	// ceil(n / B) = floor((n + B - 1) / B), the floor by reciprocal multiplication
	localparam int NW  = BYTES_W + 1;
	localparam int RSH = NW + $clog2(BYTES_PER_BLOCK);
	localparam int MW  = NW + 1;
	localparam int PW  = NW + MW;
	localparam logic [63:0] RECIP =
		((64'd1 << RSH) + 64'(BYTES_PER_BLOCK) - 64'd1) / 64'(BYTES_PER_BLOCK);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV, S_CHECK, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK_WR, S_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0]      w_q;
	logic [2:0]         c_q;
	logic [IW-1:0]      blk_q;
	logic [BW-1:0]      cnt_q;
	logic [IW-1:0]      first_q;
	logic [BW-1:0]      need_q;
	logic [IW-1:0]      lo_q;
	logic [IW-1:0]      hi_q;
	logic               set_q;
	logic               op_q;
	logic [START_W-1:0] start_q;
	logic [NW-1:0]      dv_q;
	logic [NW-1:0]      blocks_q;
	logic [1:0]         status_q;
	logic [IW-1:0]      run_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [MAP_WORD_BITS-1:0] rd_data;
	logic [MAP_WORD_BITS-1:0] wr_data;
	logic [MAP_WORD_BITS-1:0] mask;
	logic                     ram_wr;
	logic                     ram_rd;

	// block count by reciprocal
	logic [PW-1:0] prod_v;
	logic [NW-1:0] quot_v;
	logic [NW-1:0] need_v;
	logic [BYTES_W+1:0] free_end_v;

	// 8-block scan slice
	logic [BW-1:0] cnt_v;
	logic [IW-1:0] first_v;
	logic          found_v;
	logic [IW-1:0] i_v;
	logic          busy_v;
	logic          scan_end_v;
	logic [IW-1:0] b_v;
	logic [AW-1:0] last_w;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		prod_v     = PW'(dv_q) * PW'(RECIP[MW-1:0]);
		quot_v     = NW'(prod_v >> RSH);
		need_v     = blocks_q;
		free_end_v = (BYTES_W+2)'(start_q) + (BYTES_W+2)'(need_v);
	end

	// first-fit run search over eight blocks of the current word
	always_comb begin
		cnt_v   = cnt_q;
		first_v = first_q;
		found_v = 1'b0;
		i_v     = '0;
		busy_v  = 1'b0;
		for (int k = 0; k < 8; k++) begin
			i_v    = blk_q + IW'(k);
			busy_v = rd_data[{c_q, 3'(k)}] || (i_v >= IW'(TOTAL_BLOCKS));
			if (!found_v) begin
				if (busy_v) begin
					cnt_v = '0;
				end else begin
					if (cnt_v == '0) begin
						first_v = i_v;
					end
					cnt_v = cnt_v + BW'(1);
					if (cnt_v == need_q) begin
						found_v = 1'b1;
					end
				end
			end
		end
		scan_end_v = ((IW+1)'(blk_q) + (IW+1)'(8)) >= (IW+1)'(TOTAL_BLOCKS);
	end

	// bits of the current word inside [lo, hi)
	always_comb begin
		b_v = '0;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			b_v     = IW'({w_q, 6'(j)});
			mask[j] = (b_v >= lo_q) && (b_v < hi_q);
		end
		last_w = AW'((hi_q - IW'(1)) >> 6);
		if (state_q == S_CLR) begin
			wr_data = '0;
		end else if (set_q) begin
			wr_data = rd_data | mask;
		end else begin
			wr_data = rd_data & ~mask;
		end
	end

	assign ram_wr = state_q inside {S_CLR, S_MARK_WR};
	assign ram_rd = state_q inside {S_SCAN_RD, S_MARK_RD};

	bffba_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(w_q),
		.wr_data(wr_data),
		.rd_en  (ram_rd),
		.rd_addr(w_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			w_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drained result; S_DONE sets it again when it posts
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					w_q <= w_q + AW'(1);
					if (w_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.op;
						start_q <= req.start_block;
						dv_q    <= NW'(req.request_bytes) + NW'(BYTES_PER_BLOCK - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					blocks_q <= quot_v;
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					status_q <= STATUS_OK;
					run_q    <= '0;
					need_q   <= BW'(need_v);
					cnt_q    <= '0;
					first_q  <= '0;
					blk_q    <= '0;
					c_q      <= '0;
					if (need_v == '0) begin
						status_q <= STATUS_BAD;
						state_q  <= S_DONE;
					end else if (op_q == OP_ALLOC) begin
						if (need_v > NW'(TOTAL_BLOCKS)) begin
							status_q <= STATUS_NO_SPACE;
							state_q  <= S_DONE;
						end else begin
							w_q     <= '0;
							state_q <= S_SCAN_RD;
						end
					end else begin
						if (free_end_v > (BYTES_W+2)'(TOTAL_BLOCKS)) begin
							status_q <= STATUS_BAD;
							state_q  <= S_DONE;
						end else begin
							set_q   <= 1'b0;
							lo_q    <= IW'(start_q);
							hi_q    <= IW'(free_end_v);
							w_q     <= AW'(IW'(start_q) >> 6);
							state_q <= S_MARK_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q   <= cnt_v;
					first_q <= first_v;
					blk_q   <= blk_q + IW'(8);
					c_q     <= c_q + 3'd1;
					if (found_v) begin
						set_q   <= 1'b1;
						run_q   <= first_v;
						lo_q    <= first_v;
						hi_q    <= first_v + IW'(need_q);
						w_q     <= AW'(first_v >> 6);
						state_q <= S_MARK_RD;
					end else if (scan_end_v) begin
						status_q <= STATUS_NO_SPACE;
						state_q  <= S_DONE;
					end else if (c_q == 3'd7) begin
						w_q     <= w_q + AW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (w_q == last_w) begin
						state_q <= S_DONE;
					end else begin
						w_q     <= w_q + AW'(1);
						state_q <= S_MARK_RD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status    <= status_q;
						rsp_q.run_start <= START_W'(run_q);
						rsp_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_wr_only_clr_mark: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr |-> (state_q == S_CLR || state_q == S_MARK_WR))
		else $error("map write outside clear or mark");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result posted without finishing a request");

	a_scan_need_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (need_q != '0))
		else $error("scan with zero block count");

	a_no_space_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != STATUS_OK) |-> (rsp_q.run_start == '0))
		else $error("failed request carries a run start");

endmodule
`default_nettype wire
